FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the verification checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GMIG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define GMIG_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gmig_pkg.sv
// Package with widths, codes and stage types of the grid mesh index generator.
`timescale 1ns / 1ps
`default_nettype none

package gmig_pkg;

	localparam int ACT_W = 2;
	localparam int ROW_W = 7;
	localparam int SLOT_W = 8;
	localparam int SUB_W = 7;
	localparam int VTX_W = 13;
	localparam int PROD_W = ROW_W + SLOT_W;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = SUB_W;

	localparam int DEFAULT_MAX_SUB = 64;
	localparam logic [SUB_W-1:0] SUB_RESET = SUB_W'(8);
	localparam logic MODE_RESET = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SUBDIVISION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = CFG_IDX_W'(1);

	typedef enum logic [ACT_W-1:0] {
		ACT_TRIANGLE = 2'd0,
		ACT_HLINE_EDGE = 2'd1,
		ACT_BETWEEN_EDGE = 2'd2
	} act_t;

	typedef struct packed {
		logic err;
		act_t act;
		logic [ROW_W-1:0] row;
		logic [SLOT_W-1:0] slot;
		logic [SUB_W-1:0] sub;
		logic mode;
	} req_t;

	typedef struct packed {
		req_t req;
		logic [VTX_W-1:0] row_lines;
		logic [VTX_W-1:0] row_tris;
		logic [VTX_W-1:0] sub_tris;
	} prod_t;

	typedef struct packed {
		logic error;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic [VTX_W-1:0] vertex_c;
		logic [VTX_W-1:0] tri_first;
		logic [VTX_W-1:0] tri_second;
		logic tri_second_valid;
		logic boundary;
		logic diagonal;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gmig_front.sv
// First stage: effective subdivision, range check and request register.
`timescale 1ns / 1ps
`default_nettype none

module gmig_front
	import gmig_pkg::*;
#(
	parameter int MAX_SUBDIVISION = DEFAULT_MAX_SUB
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [ROW_W-1:0]  row,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [SUB_W-1:0]  sub_cfg,
	input  wire logic              mode_cfg,
	output logic                   valid_s1,
	output req_t                   req_s1
);

	logic [SUB_W-1:0] sub_eff;
	logic [SLOT_W-1:0] tris;
	logic err;

	always_comb begin
		sub_eff = sub_cfg;
		if (sub_eff == '0) begin
			sub_eff = SUB_W'(1);
		end
		if (int'(sub_eff) > MAX_SUBDIVISION) begin
			sub_eff = SUB_W'(MAX_SUBDIVISION);
		end
		tris = {sub_eff, 1'b0};
		unique case (act_t'(action))
			ACT_TRIANGLE:     err = !((row < sub_eff) && (slot < tris));
			ACT_HLINE_EDGE:   err = !((row <= sub_eff) && (slot < {1'b0, sub_eff}));
			ACT_BETWEEN_EDGE: err = !((row < sub_eff) && (slot <= tris));
			default:          err = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1.err <= err;
			req_s1.act <= act_t'(action);
			req_s1.row <= row;
			req_s1.slot <= slot;
			req_s1.sub <= sub_eff;
			req_s1.mode <= mode_cfg;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gmig_mult.sv
// Second stage: row and subdivision products for vertex and triangle bases.
`timescale 1ns / 1ps
`default_nettype none

module gmig_mult
	import gmig_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s1,
	input  req_t      req_s1,
	output logic      valid_s2,
	output prod_t     prod_s2
);

	logic [PROD_W-1:0] lines;
	logic [PROD_W-1:0] tris;
	logic [PROD_W-1:0] row_lines;
	logic [PROD_W-1:0] row_tris;
	logic [PROD_W-1:0] sub_tris;

	always_comb begin
		lines = PROD_W'(req_s1.sub) + PROD_W'(1);
		tris = PROD_W'({req_s1.sub, 1'b0});
		row_lines = PROD_W'(req_s1.row) * lines;
		row_tris = PROD_W'(req_s1.row) * tris;
		sub_tris = PROD_W'(req_s1.sub) * tris;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.req <= req_s1;
			prod_s2.row_lines <= row_lines[VTX_W-1:0];
			prod_s2.row_tris <= row_tris[VTX_W-1:0];
			prod_s2.sub_tris <= sub_tris[VTX_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gmig_assemble.sv
// Third stage: vertex and adjacency selection into the output register.
`timescale 1ns / 1ps
`default_nettype none

module gmig_assemble
	import gmig_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s2,
	input  prod_t     prod_s2,
	output logic      valid_s3,
	output res_t      res_s3
);

	logic [VTX_W-1:0] sub13;
	logic [VTX_W-1:0] lines13;
	logic [VTX_W-1:0] tris13;
	logic [VTX_W-1:0] col13;
	logic [VTX_W-1:0] slot13;
	logic [VTX_W-1:0] col2;
	logic [VTX_W-1:0] slot2;
	logic [VTX_W-1:0] ul;
	logic [SLOT_W-2:0] col;
	logic flip_col;
	logic flip_slot;
	res_t res;

	always_comb begin
		col = prod_s2.req.slot[SLOT_W-1:1];
		sub13 = VTX_W'(prod_s2.req.sub);
		lines13 = sub13 + VTX_W'(1);
		tris13 = sub13 << 1;
		col13 = VTX_W'(col);
		slot13 = VTX_W'(prod_s2.req.slot);
		col2 = col13 << 1;
		slot2 = slot13 << 1;
		ul = prod_s2.row_lines + col13;
		flip_col = prod_s2.req.mode && col[0];
		flip_slot = prod_s2.req.mode && prod_s2.req.slot[0];
		res = '0;
		if (prod_s2.req.err) begin
			res.error = 1'b1;
		end else begin
			case (prod_s2.req.act)
				ACT_TRIANGLE: begin
					if (!flip_col) begin
						res.vertex_a = ul;
						if (!prod_s2.req.slot[0]) begin
							res.vertex_b = ul + lines13;
							res.vertex_c = ul + lines13 + VTX_W'(1);
						end else begin
							res.vertex_b = ul + lines13 + VTX_W'(1);
							res.vertex_c = ul + VTX_W'(1);
						end
					end else begin
						res.vertex_a = ul + VTX_W'(1);
						if (!prod_s2.req.slot[0]) begin
							res.vertex_b = ul;
							res.vertex_c = ul + lines13;
						end else begin
							res.vertex_b = ul + lines13;
							res.vertex_c = ul + lines13 + VTX_W'(1);
						end
					end
					res.tri_first = prod_s2.row_tris + slot13;
				end
				ACT_HLINE_EDGE: begin
					res.vertex_a = prod_s2.row_lines + slot13;
					res.vertex_b = prod_s2.row_lines + slot13 + VTX_W'(1);
					if (prod_s2.req.row == '0) begin
						res.boundary = 1'b1;
						res.tri_first = slot2 + VTX_W'(!flip_slot);
					end else if (prod_s2.req.row == prod_s2.req.sub) begin
						res.boundary = 1'b1;
						res.tri_first = prod_s2.sub_tris - tris13 + slot2 + VTX_W'(flip_slot);
					end else begin
						res.tri_first = prod_s2.row_tris - tris13 + slot2 + VTX_W'(flip_slot);
						res.tri_second = prod_s2.row_tris + slot2 + VTX_W'(!flip_slot);
						res.tri_second_valid = 1'b1;
					end
				end
				ACT_BETWEEN_EDGE: begin
					if (!prod_s2.req.slot[0]) begin
						res.vertex_a = ul;
						res.vertex_b = ul + lines13;
						if (col == '0) begin
							res.boundary = 1'b1;
							res.tri_first = prod_s2.row_tris;
						end else if (col == prod_s2.req.sub) begin
							res.boundary = 1'b1;
							res.tri_first = prod_s2.row_tris + tris13 - VTX_W'(1);
						end else begin
							res.tri_first = prod_s2.row_tris + col2 - VTX_W'(1);
							res.tri_second = prod_s2.row_tris + col2;
							res.tri_second_valid = 1'b1;
						end
					end else begin
						if (!flip_col) begin
							res.vertex_a = ul;
							res.vertex_b = ul + lines13 + VTX_W'(1);
						end else begin
							res.vertex_a = ul + VTX_W'(1);
							res.vertex_b = ul + lines13;
						end
						res.diagonal = 1'b1;
						res.tri_first = prod_s2.row_tris + col2;
						res.tri_second = prod_s2.row_tris + col2 + VTX_W'(1);
						res.tri_second_valid = 1'b1;
					end
				end
				default: begin
					res.error = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_mesh_index_generator_top.sv
// Top level of the grid mesh index generator: configuration and stage handshake.
//
// Requests enter on the in_valid/in_ready channel with action, row and slot;
// each request yields exactly one result on the out_valid/out_ready channel.
// A transfer happens on a rising edge with valid and ready both high.
// The block is a three stage pipeline: range check, products of the row
// with the grid size, then vertex and triangle selection into the output
// register. A request passes the request, product and output registers before
// out_valid. One request is taken every cycle unless the receiver stalls.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles close up and up to three results wait inside. The user
// must write subdivision and pattern mode on cfg_we/cfg_index/cfg_wdata only
// while the pipeline is empty; the block does not enforce it. Asynchronous reset
// empties the pipeline, sets subdivision to eight, pattern mode to alternating.
`timescale 1ns / 1ps
`default_nettype none

module grid_mesh_index_generator_top
	import gmig_pkg::*;
#(
	parameter int MAX_SUBDIVISION = DEFAULT_MAX_SUB
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ACT_W-1:0]      action,
	input  wire logic [ROW_W-1:0]      row,
	input  wire logic [SLOT_W-1:0]     slot,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       error,
	output logic [VTX_W-1:0]           vertex_a,
	output logic [VTX_W-1:0]           vertex_b,
	output logic [VTX_W-1:0]           vertex_c,
	output logic [VTX_W-1:0]           tri_first,
	output logic [VTX_W-1:0]           tri_second,
	output logic                       tri_second_valid,
	output logic                       boundary,
	output logic                       diagonal
);

	logic [SUB_W-1:0] sub_q;
	logic mode_q;
	logic en1;
	logic en2;
	logic en3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	req_t req_s1;
	prod_t prod_s2;
	res_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= SUB_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SUBDIVISION:  sub_q <= cfg_wdata;
				CFG_PATTERN_MODE: mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign en3 = !valid_s3 || out_ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;

	gmig_front #(
		.MAX_SUBDIVISION(MAX_SUBDIVISION)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en1),
		.in_valid(in_valid),
		.action(action),
		.row(row),
		.slot(slot),
		.sub_cfg(sub_q),
		.mode_cfg(mode_q),
		.valid_s1(valid_s1),
		.req_s1(req_s1)
	);

	gmig_mult u_mult (
		.clk(clk),
		.arst_n(arst_n),
		.en(en2),
		.valid_s1(valid_s1),
		.req_s1(req_s1),
		.valid_s2(valid_s2),
		.prod_s2(prod_s2)
	);

	gmig_assemble u_assemble (
		.clk(clk),
		.arst_n(arst_n),
		.en(en3),
		.valid_s2(valid_s2),
		.prod_s2(prod_s2),
		.valid_s3(valid_s3),
		.res_s3(res_s3)
	);

	assign out_valid = valid_s3;
	assign error = res_s3.error;
	assign vertex_a = res_s3.vertex_a;
	assign vertex_b = res_s3.vertex_b;
	assign vertex_c = res_s3.vertex_c;
	assign tri_first = res_s3.tri_first;
	assign tri_second = res_s3.tri_second;
	assign tri_second_valid = res_s3.tri_second_valid;
	assign boundary = res_s3.boundary;
	assign diagonal = res_s3.diagonal;

endmodule

`default_nettype wire

FILE: hw/rtl/gmig_checker.sv
// Port-level checker of the grid mesh index generator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gmig_checker
	import gmig_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  error,
	input wire logic [VTX_W-1:0]      vertex_a,
	input wire logic [VTX_W-1:0]      vertex_b,
	input wire logic [VTX_W-1:0]      vertex_c,
	input wire logic [VTX_W-1:0]      tri_first,
	input wire logic [VTX_W-1:0]      tri_second,
	input wire logic                  tri_second_valid,
	input wire logic                  boundary,
	input wire logic                  diagonal
);

	`GMIG_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid, "result valid during reset")
	`GMIG_ASSERT(a_empty_ready, clk, arst_n, !out_valid |-> in_ready, "empty pipeline refuses input")
	`GMIG_ASSERT(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(vertex_a) && $stable(tri_first) && $stable(error), "stalled result changed")
	`GMIG_ASSERT(a_error_clear, clk, arst_n, out_valid && error |-> vertex_a == '0 && vertex_b == '0 && vertex_c == '0 && tri_first == '0 && tri_second == '0 && !tri_second_valid && !boundary && !diagonal, "error result carries data")
	`GMIG_ASSERT(a_diag_inner, clk, arst_n, out_valid && diagonal |-> tri_second_valid && !boundary && !error, "diagonal edge not inner")

endmodule

bind grid_mesh_index_generator_top gmig_checker u_checker (.*);

`default_nettype wire

FILE: tb/grid_mesh_index_generator_top_tb.sv
// Self-checking testbench for the grid mesh index generator top level.
`timescale 1ns / 1ps

module grid_mesh_index_generator_top_tb;
	import gmig_pkg::*;

	localparam int MAX_SUB = DEFAULT_MAX_SUB;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX = 10;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [ACT_W-1:0] action;
	logic [ROW_W-1:0] row;
	logic [SLOT_W-1:0] slot;
	logic out_valid;
	logic out_ready;
	logic error;
	logic [VTX_W-1:0] vertex_a;
	logic [VTX_W-1:0] vertex_b;
	logic [VTX_W-1:0] vertex_c;
	logic [VTX_W-1:0] tri_first;
	logic [VTX_W-1:0] tri_second;
	logic tri_second_valid;
	logic boundary;
	logic diagonal;

	logic [SUB_W-1:0] model_sub;
	logic model_mode;
	res_t expected_indices[$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;

	grid_mesh_index_generator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.row(row),
		.slot(slot),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.error(error),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.vertex_c(vertex_c),
		.tri_first(tri_first),
		.tri_second(tri_second),
		.tri_second_valid(tri_second_valid),
		.boundary(boundary),
		.diagonal(diagonal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_sub();
		int s;
		s = model_sub;
		if (s == 0) s = 1;
		if (s > MAX_SUB) s = MAX_SUB;
		return s;
	endfunction

	function automatic res_t predict_indices(logic [ACT_W-1:0] act, logic [ROW_W-1:0] r_in,
			logic [SLOT_W-1:0] k_in);
		int s, lines, tpl, r, k, col, ul;
		int va, vb, vc, t0, t1;
		bit flip;
		res_t p;
		s = eff_sub();
		lines = s + 1;
		tpl = 2 * s;
		r = r_in;
		k = k_in;
		va = 0;
		vb = 0;
		vc = 0;
		t0 = 0;
		t1 = 0;
		p = '0;
		if (act == ACT_TRIANGLE && r < s && k < tpl) begin
			col = k / 2;
			ul = r * lines + col;
			flip = model_mode && (col % 2 == 1);
			if (!flip) begin
				va = ul;
				if (k % 2 == 0) begin
					vb = ul + lines;
					vc = ul + lines + 1;
				end else begin
					vb = ul + lines + 1;
					vc = ul + 1;
				end
			end else begin
				if (k % 2 == 0) begin
					va = ul + 1;
					vb = ul;
					vc = ul + lines;
				end else begin
					va = ul + 1;
					vb = ul + lines;
					vc = ul + lines + 1;
				end
			end
			t0 = tpl * r + k;
		end else if (act == ACT_HLINE_EDGE && r <= s && k < s) begin
			flip = model_mode && (k % 2 == 1);
			va = r * lines + k;
			vb = va + 1;
			if (r == 0) begin
				p.boundary = 1'b1;
				t0 = 2 * k + (flip ? 0 : 1);
			end else if (r == s) begin
				p.boundary = 1'b1;
				t0 = tpl * (s - 1) + 2 * k + (flip ? 1 : 0);
			end else begin
				t0 = tpl * (r - 1) + 2 * k + (flip ? 1 : 0);
				t1 = tpl * r + 2 * k + (flip ? 0 : 1);
				p.tri_second_valid = 1'b1;
			end
		end else if (act == ACT_BETWEEN_EDGE && r < s && k <= tpl) begin
			col = k / 2;
			if (k % 2 == 0) begin
				va = r * lines + col;
				vb = va + lines;
				if (col == 0) begin
					p.boundary = 1'b1;
					t0 = tpl * r;
				end else if (col == s) begin
					p.boundary = 1'b1;
					t0 = tpl * (r + 1) - 1;
				end else begin
					t0 = tpl * r + 2 * col - 1;
					t1 = tpl * r + 2 * col;
					p.tri_second_valid = 1'b1;
				end
			end else begin
				flip = model_mode && (col % 2 == 1);
				if (!flip) begin
					va = r * lines + col;
					vb = (r + 1) * lines + col + 1;
				end else begin
					va = r * lines + col + 1;
					vb = (r + 1) * lines + col;
				end
				p.diagonal = 1'b1;
				t0 = tpl * r + 2 * col;
				t1 = t0 + 1;
				p.tri_second_valid = 1'b1;
			end
		end else begin
			p.error = 1'b1;
		end
		p.vertex_a = VTX_W'(va);
		p.vertex_b = VTX_W'(vb);
		p.vertex_c = VTX_W'(vc);
		p.tri_first = VTX_W'(t0);
		p.tri_second = VTX_W'(t1);
		return p;
	endfunction

	task automatic send_request(input logic [ACT_W-1:0] act, input logic [ROW_W-1:0] r,
			input logic [SLOT_W-1:0] k);
		int gap;
		bit taken;
		res_t want;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		row <= r;
		slot <= k;
		want = predict_indices(act, r, k);
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		expected_indices = {expected_indices, want};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_indices.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SUBDIVISION) model_sub = data;
		else model_mode = data[0];
		@(posedge clk);
	endtask

	task automatic set_grid(input int sub, input bit mode);
		drain_results();
		write_reg(CFG_SUBDIVISION, CFG_DATA_W'(sub));
		write_reg(CFG_PATTERN_MODE, {(CFG_DATA_W-1)'($urandom_range(63)), mode});
	endtask

	function automatic int pick_value(int max_val);
		int sel;
		sel = $urandom_range(99);
		if (sel < 15) return 0;
		if (sel < 30) return max_val;
		if (sel < 34) return max_val + 1;
		return $urandom_range(max_val);
	endfunction

	task automatic send_random_request();
		logic [ACT_W-1:0] act;
		int s, rmax, kmax;
		s = eff_sub();
		if ($urandom_range(99) < 12) begin
			send_request(ACT_W'($urandom_range(3)), ROW_W'($urandom), SLOT_W'($urandom));
		end else begin
			act = ACT_W'($urandom_range(2));
			case (act)
				ACT_TRIANGLE: begin
					rmax = s - 1;
					kmax = 2 * s - 1;
				end
				ACT_HLINE_EDGE: begin
					rmax = s;
					kmax = s - 1;
				end
				default: begin
					rmax = s - 1;
					kmax = 2 * s;
				end
			endcase
			send_request(act, ROW_W'(pick_value(rmax)), SLOT_W'(pick_value(kmax)));
		end
	endtask

	task automatic test_reset_values();
		send_request(ACT_TRIANGLE, 0, 0);
		send_request(ACT_TRIANGLE, 7, 15);
		send_request(ACT_TRIANGLE, 0, 2);
		send_request(ACT_TRIANGLE, 0, 3);
		send_request(ACT_TRIANGLE, 8, 0);
		send_request(ACT_TRIANGLE, 0, 16);
		send_request(ACT_HLINE_EDGE, 0, 0);
		send_request(ACT_HLINE_EDGE, 8, 7);
		send_request(ACT_HLINE_EDGE, 3, 1);
		send_request(ACT_HLINE_EDGE, 9, 0);
		send_request(ACT_HLINE_EDGE, 0, 8);
		send_request(ACT_BETWEEN_EDGE, 0, 0);
		send_request(ACT_BETWEEN_EDGE, 7, 16);
		send_request(ACT_BETWEEN_EDGE, 2, 4);
		send_request(ACT_BETWEEN_EDGE, 2, 3);
		send_request(ACT_BETWEEN_EDGE, 0, 17);
		send_request(ACT_UNUSED, 0, 0);
	endtask

	task automatic test_grid_extremes();
		set_grid(64, 1'b0);
		send_request(ACT_TRIANGLE, 63, 127);
		send_request(ACT_BETWEEN_EDGE, 63, 128);
		send_request(ACT_BETWEEN_EDGE, 63, 127);
		send_request(ACT_HLINE_EDGE, 64, 63);
		send_request(ACT_UNUSED, 127, 255);
		set_grid(0, 1'b1);
		send_request(ACT_TRIANGLE, 0, 1);
		send_request(ACT_BETWEEN_EDGE, 0, 2);
		set_grid(127, 1'b1);
		send_request(ACT_HLINE_EDGE, 64, 63);
		send_request(ACT_TRIANGLE, 64, 0);
	endtask

	task automatic test_backpressure();
		set_grid(16, 1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 150;
		repeat (30) send_random_request();
		drain_results();
	endtask

	task automatic test_random_traffic();
		int subs[8] = '{64, 1, 5, 127, 0, 33, 64, 2};
		int idle_set[4] = '{0, 59, 0, 28};
		int stall_set[4] = '{0, 0, 59, 28};
		int sub;
		for (int ph = 0; ph < 8; ph++) begin
			sub = subs[ph];
			if (ph == 7) sub = $urandom_range(63, 2);
			send_idle_pct = 0;
			recv_stall_pct = 0;
			set_grid(sub, ph % 2 == 1);
			send_idle_pct = idle_set[ph % 4];
			recv_stall_pct = stall_set[ph % 4];
			repeat (175) send_random_request();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin : receiver
			int hold_left;
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(negedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got.error = error;
			got.vertex_a = vertex_a;
			got.vertex_b = vertex_b;
			got.vertex_c = vertex_c;
			got.tri_first = tri_first;
			got.tri_second = tri_second;
			got.tri_second_valid = tri_second_valid;
			got.boundary = boundary;
			got.diagonal = diagonal;
			if (expected_indices.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result transfer at cycle %0d", cycle_count);
			end else begin
				want = expected_indices.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch at cycle %0d: err %b/%b va %0d/%0d vb %0d/%0d vc %0d/%0d",
							cycle_count, want.error, got.error,
							want.vertex_a, got.vertex_a, want.vertex_b, got.vertex_b,
							want.vertex_c, got.vertex_c);
						$display("  t0 %0d/%0d t1 %0d/%0d t1v %b/%b bnd %b/%b diag %b/%b",
							want.tri_first, got.tri_first,
							want.tri_second, got.tri_second,
							want.tri_second_valid, got.tri_second_valid,
							want.boundary, got.boundary, want.diagonal, got.diagonal);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("grid_mesh_index_generator_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		action = '0;
		row = '0;
		slot = '0;
		model_sub = SUB_RESET;
		model_mode = MODE_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_grid_extremes();
		test_backpressure();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_indices.size() == 0) begin
			$display("grid_mesh_index_generator_top_tb: done, clean");
		end else begin
			$display("grid_mesh_index_generator_top_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: grid_mesh_index_generator_top.f
+incdir+hw/rtl
hw/rtl/gmig_pkg.sv
hw/rtl/gmig_front.sv
hw/rtl/gmig_mult.sv
hw/rtl/gmig_assemble.sv
hw/rtl/grid_mesh_index_generator_top.sv
hw/rtl/gmig_checker.sv
tb/grid_mesh_index_generator_top_tb.sv
